// ----- src/irsc_pkg.sv -----
package irsc_pkg;

    // protocol codes
    localparam logic [4:0] CMD_RC5      = 5'd0;
    localparam logic [4:0] CMD_RC5X     = 5'd1;
    localparam logic [4:0] CMD_RC5SZ    = 5'd2;
    localparam logic [4:0] CMD_SONY12   = 5'd3;
    localparam logic [4:0] CMD_SONY15   = 5'd4;
    localparam logic [4:0] CMD_SONY20   = 5'd5;
    localparam logic [4:0] CMD_JVC      = 5'd6;
    localparam logic [4:0] CMD_NEC      = 5'd7;
    localparam logic [4:0] CMD_NECX     = 5'd8;
    localparam logic [4:0] CMD_NEC32    = 5'd9;
    localparam logic [4:0] CMD_SANYO    = 5'd10;
    localparam logic [4:0] CMD_RC6_0    = 5'd11;
    localparam logic [4:0] CMD_RC6_20   = 5'd12;
    localparam logic [4:0] CMD_RC6_24   = 5'd13;
    localparam logic [4:0] CMD_RC6_32   = 5'd14;
    localparam logic [4:0] CMD_RC6_MCE  = 5'd15;
    localparam logic [4:0] CMD_SHARP    = 5'd16;
    localparam logic [4:0] CMD_DVD      = 5'd17;

    // durations in microseconds, already rounded
    localparam logic [15:0] RC5_U    = 16'd889;
    localparam logic [15:0] RC5_U4   = 16'd3556;
    localparam logic [15:0] RC6_U    = 16'd444;
    localparam logic [15:0] RC6_U2   = 16'd889;
    localparam logic [15:0] RC6_U6   = 16'd2667;
    localparam logic [15:0] SONY_U   = 16'd600;
    localparam logic [15:0] SONY_U2  = 16'd1200;
    localparam logic [15:0] SONY_U4  = 16'd2400;
    localparam logic [15:0] NEC_U    = 16'd563;
    localparam logic [15:0] NEC_U3   = 16'd1688;
    localparam logic [15:0] NEC_HM   = 16'd9000;
    localparam logic [15:0] NEC_HS   = 16'd4500;
    localparam logic [15:0] JVC_U    = 16'd525;
    localparam logic [15:0] JVC_U3   = 16'd1575;
    localparam logic [15:0] JVC_HM   = 16'd8400;
    localparam logic [15:0] JVC_HS   = 16'd4200;
    localparam logic [15:0] SHP_M    = 16'd320;
    localparam logic [15:0] SHP_S0   = 16'd680;
    localparam logic [15:0] SHP_S1   = 16'd1680;
    localparam logic [15:0] SHP_GAP  = 16'd40000;
    localparam logic [15:0] DVD_HM   = 16'd4000;
    localparam logic [15:0] DVD_HS   = 16'd3900;
    localparam logic [15:0] DVD_M    = 16'd550;
    localparam logic [15:0] DVD_S0   = 16'd900;
    localparam logic [15:0] DVD_S1   = 16'd1900;

    typedef enum logic [2:0] {
        SK_MARK, SK_SPACE, SK_PD, SK_PW, SK_MAN, SK_END, SK_BAD
    } seg_kind_t;

    // one segment of a frame program
    typedef struct packed {
        seg_kind_t   kind;
        logic        msb_first;
        logic        one_mark;
        logic [5:0]  count;
        logic [31:0] val;
        logic [15:0] len_a;
        logic [15:0] len_b;
        logic [15:0] len_c;
    } seg_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       step;
        logic       fin;
        logic [3:0] seg;
        logic [4:0] bidx;
        logic       ph;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       seg_end;
        logic       single;
        logic [5:0] count;
        logic       emit_req;
        logic       out_free;
    } dp_stat_t;

    function automatic seg_t mk(input seg_kind_t k, input logic msb, input logic one,
                                input logic [5:0] n, input logic [31:0] v,
                                input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] c);
        seg_t r;
        r.kind      = k;
        r.msb_first = msb;
        r.one_mark  = one;
        r.count     = n;
        r.val       = v;
        r.len_a     = a;
        r.len_b     = b;
        r.len_c     = c;
        return r;
    endfunction

    function automatic seg_t pd(input logic [31:0] v, input logic [5:0] n,
                                input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] c);
        return mk(SK_PD, 1'b0, 1'b0, n, v, a, b, c);
    endfunction

    function automatic seg_t one_edge(input seg_kind_t k, input logic [15:0] a);
        return mk(k, 1'b0, 1'b0, 6'd1, 32'd0, a, 16'd0, 16'd0);
    endfunction

    // frame program: segment idx of protocol cmd for scancode s
    function automatic seg_t seg_lookup(input logic [4:0] cmd, input logic [3:0] idx,
                                        input logic [31:0] s);
        seg_t        r;
        logic [31:0] w;
        logic [5:0]  n;
        r = one_edge(SK_END, 16'd0);
        w = 32'd0;
        n = 6'd0;
        case (cmd) inside
            CMD_RC5, CMD_RC5X, CMD_RC5SZ: begin
                case (idx)
                    4'd0: r = one_edge(SK_MARK, RC5_U);
                    4'd1: begin
                        if (cmd == CMD_RC5) w = {31'd0, ~s[6]};
                        else if (cmd == CMD_RC5SZ) w = {31'd0, s[13]};
                        else w = {31'd0, ~s[14]};
                        r = mk(SK_MAN, 1'b1, 1'b0, 6'd1, w, RC5_U, 16'd0, 16'd0);
                    end
                    4'd2: r = mk(SK_MAN, 1'b1, 1'b0, 6'd1, 32'd0, RC5_U, 16'd0, 16'd0);
                    4'd3: begin
                        if (cmd == CMD_RC5)
                            r = mk(SK_MAN, 1'b1, 1'b0, 6'd5, s >> 8, RC5_U, 16'd0, 16'd0);
                        else if (cmd == CMD_RC5SZ)
                            r = mk(SK_MAN, 1'b1, 1'b0, 6'd6, s >> 6, RC5_U, 16'd0, 16'd0);
                        else
                            r = mk(SK_MAN, 1'b1, 1'b0, 6'd5, s >> 16, RC5_U, 16'd0, 16'd0);
                    end
                    4'd4: begin
                        if (cmd == CMD_RC5X) r = one_edge(SK_SPACE, RC5_U4);
                        else r = mk(SK_MAN, 1'b1, 1'b0, 6'd6, s, RC5_U, 16'd0, 16'd0);
                    end
                    4'd5: begin
                        if (cmd == CMD_RC5X)
                            r = mk(SK_MAN, 1'b1, 1'b0, 6'd6, s >> 8, RC5_U, 16'd0, 16'd0);
                    end
                    4'd6: begin
                        if (cmd == CMD_RC5X)
                            r = mk(SK_MAN, 1'b1, 1'b0, 6'd6, s, RC5_U, 16'd0, 16'd0);
                    end
                    default: r = one_edge(SK_END, 16'd0);
                endcase
            end
            CMD_SONY12, CMD_SONY15, CMD_SONY20: begin
                case (idx)
                    4'd0: r = one_edge(SK_MARK, SONY_U4);
                    4'd1: r = one_edge(SK_SPACE, SONY_U);
                    4'd2: r = mk(SK_PW, 1'b0, 1'b0, 6'd7, s, SONY_U, SONY_U2, SONY_U);
                    4'd3: begin
                        n = (cmd == CMD_SONY15) ? 6'd8 : 6'd5;
                        r = mk(SK_PW, 1'b0, 1'b0, n, s >> 16, SONY_U, SONY_U2, SONY_U);
                    end
                    4'd4: begin
                        if (cmd == CMD_SONY20)
                            r = mk(SK_PW, 1'b0, 1'b0, 6'd8, s >> 8, SONY_U, SONY_U2, SONY_U);
                    end
                    default: r = one_edge(SK_END, 16'd0);
                endcase
            end
            CMD_JVC: begin
                w = {16'd0, s[7:0], s[15:8]};
                case (idx)
                    4'd0: r = one_edge(SK_MARK, JVC_HM);
                    4'd1: r = one_edge(SK_SPACE, JVC_HS);
                    4'd2: r = pd(w, 6'd16, JVC_U, JVC_U, JVC_U3);
                    4'd3: r = one_edge(SK_MARK, JVC_U);
                    default: r = one_edge(SK_END, 16'd0);
                endcase
            end
            CMD_NEC, CMD_NECX, CMD_NEC32: begin
                case (idx)
                    4'd0: r = one_edge(SK_MARK, NEC_HM);
                    4'd1: r = one_edge(SK_SPACE, NEC_HS);
                    4'd2: begin
                        w = (cmd == CMD_NEC) ? (s >> 8) : (s >> 16);
                        r = pd(w, 6'd8, NEC_U, NEC_U, NEC_U3);
                    end
                    4'd3: begin
                        if (cmd == CMD_NEC) w = ~(s >> 8);
                        else if (cmd == CMD_NECX) w = s >> 8;
                        else w = s >> 24;
                        r = pd(w, 6'd8, NEC_U, NEC_U, NEC_U3);
                    end
                    4'd4: r = pd(s, 6'd8, NEC_U, NEC_U, NEC_U3);
                    4'd5: begin
                        w = (cmd == CMD_NEC32) ? (s >> 8) : ~s;
                        r = pd(w, 6'd8, NEC_U, NEC_U, NEC_U3);
                    end
                    4'd6: r = one_edge(SK_MARK, NEC_U);
                    default: r = one_edge(SK_END, 16'd0);
                endcase
            end
            CMD_SANYO: begin
                case (idx)
                    4'd0: r = one_edge(SK_MARK, NEC_HM);
                    4'd1: r = one_edge(SK_SPACE, NEC_HS);
                    4'd2: r = pd(s >> 8, 6'd13, NEC_U, NEC_U, NEC_U3);
                    4'd3: r = pd(~(s >> 8), 6'd13, NEC_U, NEC_U, NEC_U3);
                    4'd4: r = pd(s, 6'd8, NEC_U, NEC_U, NEC_U3);
                    4'd5: r = pd(~s, 6'd8, NEC_U, NEC_U, NEC_U3);
                    4'd6: r = one_edge(SK_MARK, NEC_U);
                    default: r = one_edge(SK_END, 16'd0);
                endcase
            end
            CMD_RC6_0, CMD_RC6_20, CMD_RC6_24, CMD_RC6_32, CMD_RC6_MCE: begin
                case (idx)
                    4'd0: r = one_edge(SK_MARK, RC6_U6);
                    4'd1: r = one_edge(SK_SPACE, RC6_U2);
                    4'd2: begin
                        w = (cmd == CMD_RC6_0) ? 32'd8 : 32'd14;
                        r = mk(SK_MAN, 1'b1, 1'b1, 6'd4, w, RC6_U, 16'd0, 16'd0);
                    end
                    4'd3: r = mk(SK_MAN, 1'b1, 1'b1, 6'd1, 32'd0, RC6_U2, 16'd0, 16'd0);
                    4'd4: begin
                        if (cmd == CMD_RC6_0) n = 6'd16;
                        else if (cmd == CMD_RC6_20) n = 6'd20;
                        else if (cmd == CMD_RC6_24) n = 6'd24;
                        else n = 6'd32;
                        r = mk(SK_MAN, 1'b1, 1'b1, n, s, RC6_U, 16'd0, 16'd0);
                    end
                    default: r = one_edge(SK_END, 16'd0);
                endcase
            end
            CMD_SHARP: begin
                case (idx)
                    4'd0: r = pd(s >> 8, 6'd5, SHP_M, SHP_S0, SHP_S1);
                    4'd1: r = pd(s, 6'd8, SHP_M, SHP_S0, SHP_S1);
                    4'd2: r = pd(32'd1, 6'd2, SHP_M, SHP_S0, SHP_S1);
                    4'd3: r = one_edge(SK_MARK, SHP_M);
                    4'd4: r = one_edge(SK_SPACE, SHP_GAP);
                    4'd5: r = pd(s >> 8, 6'd5, SHP_M, SHP_S0, SHP_S1);
                    4'd6: r = pd(~s, 6'd8, SHP_M, SHP_S0, SHP_S1);
                    4'd7: r = pd(~32'd1, 6'd2, SHP_M, SHP_S0, SHP_S1);
                    4'd8: r = one_edge(SK_MARK, SHP_M);
                    default: r = one_edge(SK_END, 16'd0);
                endcase
            end
            CMD_DVD: begin
                w = {8'd0, ~s[11:0], s[11:0]};
                case (idx)
                    4'd0: r = one_edge(SK_MARK, DVD_HM);
                    4'd1: r = one_edge(SK_SPACE, DVD_HS);
                    4'd2: r = mk(SK_PD, 1'b1, 1'b0, 6'd24, w, DVD_M, DVD_S0, DVD_S1);
                    4'd3: r = one_edge(SK_MARK, DVD_M);
                    default: r = one_edge(SK_END, 16'd0);
                endcase
            end
            default: r = one_edge(SK_BAD, 16'd0);
        endcase
        return r;
    endfunction

endpackage

// ----- src/irsc_ctrl.sv -----
module irsc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  irsc_pkg::dp_stat_t   stat,
    output irsc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] seg_reg, seg_next;
    logic [4:0] bidx_reg, bidx_next;
    logic       ph_reg, ph_next;
    logic       last_ph;
    logic       last_bit;

    assign in_ready = (state_reg == ST_IDLE);
    assign last_ph  = stat.single || ph_reg;
    assign last_bit = ({1'b0, bidx_reg} == (stat.count - 6'd1));

    // sequencing over segments, bits and edges
    always_comb begin
        state_next = state_reg;
        seg_next   = seg_reg;
        bidx_next  = bidx_reg;
        ph_next    = ph_reg;
        cmd        = '0;
        cmd.seg    = seg_reg;
        cmd.bidx   = bidx_reg;
        cmd.ph     = ph_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    seg_next   = 4'd0;
                    bidx_next  = 5'd0;
                    ph_next    = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (stat.seg_end) begin
                    if (stat.out_free) begin
                        cmd.fin    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (!stat.emit_req || stat.out_free) begin
                    cmd.step = 1'b1;
                    if (last_ph) begin
                        ph_next = 1'b0;
                        if (last_bit) begin
                            bidx_next = 5'd0;
                            seg_next  = seg_reg + 4'd1;
                        end else begin
                            bidx_next = bidx_reg + 5'd1;
                        end
                    end else begin
                        ph_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seg_reg   <= 4'd0;
            bidx_reg  <= 5'd0;
            ph_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
            bidx_reg  <= bidx_next;
            ph_reg    <= ph_next;
        end
    end

endmodule

// ----- src/irsc_dp.sv -----
module irsc_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [4:0]           in_cmd,
    input  logic [31:0]          in_scancode,
    input  irsc_pkg::ctrl_cmd_t  cmd,
    output irsc_pkg::dp_stat_t   stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          out_pulse,
    output logic [15:0]          out_space,
    output logic                 out_last,
    output logic                 out_unsup
);

    localparam logic [1:0] OPEN_NONE  = 2'd0;
    localparam logic [1:0] OPEN_MARK  = 2'd1;
    localparam logic [1:0] OPEN_SPACE = 2'd2;

    logic [4:0]     cmd_reg;
    logic [31:0]    sc_reg;
    irsc_pkg::seg_t seg;
    logic [5:0]     sel_full;
    logic           dbit;
    logic           e_mark;
    logic [15:0]    e_len;
    logic           emit_mid;
    logic           out_free;

    logic [1:0]     open_reg, open_next;
    logic [15:0]    mk_reg, mk_next;
    logic [15:0]    sp_reg, sp_next;
    logic           ov_reg, ov_next;
    logic [15:0]    op_reg, op_next;
    logic [15:0]    os_reg, os_next;
    logic           ol_reg, ol_next;
    logic           ou_reg, ou_next;

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_cmd;
            sc_reg  <= in_scancode;
        end
    end

    // current segment and the edge it gives
    assign seg      = irsc_pkg::seg_lookup(cmd_reg, cmd.seg, sc_reg);
    assign sel_full = seg.msb_first ? (seg.count - 6'd1 - {1'b0, cmd.bidx})
                                    : {1'b0, cmd.bidx};
    assign dbit     = seg.val[sel_full[4:0]];

    always_comb begin
        e_mark = 1'b1;
        e_len  = seg.len_a;
        case (seg.kind)
            irsc_pkg::SK_MARK: begin
                e_mark = 1'b1;
                e_len  = seg.len_a;
            end
            irsc_pkg::SK_SPACE: begin
                e_mark = 1'b0;
                e_len  = seg.len_a;
            end
            irsc_pkg::SK_PD: begin
                e_mark = !cmd.ph;
                e_len  = !cmd.ph ? seg.len_a : (dbit ? seg.len_c : seg.len_b);
            end
            irsc_pkg::SK_PW: begin
                e_mark = !cmd.ph;
                e_len  = !cmd.ph ? (dbit ? seg.len_b : seg.len_a) : seg.len_c;
            end
            irsc_pkg::SK_MAN: begin
                e_mark = (dbit == seg.one_mark) ^ cmd.ph;
                e_len  = seg.len_a;
            end
            default: begin
                e_mark = 1'b1;
                e_len  = seg.len_a;
            end
        endcase
    end

    assign emit_mid = e_mark && (open_reg == OPEN_SPACE);
    assign out_free = !ov_reg || out_ready;

    assign stat.seg_end  = (seg.kind == irsc_pkg::SK_END) || (seg.kind == irsc_pkg::SK_BAD);
    assign stat.single   = (seg.kind == irsc_pkg::SK_MARK) || (seg.kind == irsc_pkg::SK_SPACE);
    assign stat.count    = seg.count;
    assign stat.emit_req = emit_mid;
    assign stat.out_free = out_free;

    // edge merging and pair output
    always_comb begin
        open_next = open_reg;
        mk_next   = mk_reg;
        sp_next   = sp_reg;
        ov_next   = ov_reg && !out_ready;
        op_next   = op_reg;
        os_next   = os_reg;
        ol_next   = ol_reg;
        ou_next   = ou_reg;
        if (cmd.load) begin
            open_next = OPEN_NONE;
        end else if (cmd.fin) begin
            ov_next   = 1'b1;
            ol_next   = 1'b1;
            os_next   = 16'd0;
            open_next = OPEN_NONE;
            if (seg.kind == irsc_pkg::SK_BAD) begin
                op_next = 16'd0;
                ou_next = 1'b1;
            end else begin
                op_next = mk_reg;
                ou_next = 1'b0;
            end
        end else if (cmd.step) begin
            if (e_mark) begin
                case (open_reg)
                    OPEN_MARK: mk_next = mk_reg + e_len;
                    OPEN_SPACE: begin
                        ov_next   = 1'b1;
                        op_next   = mk_reg;
                        os_next   = sp_reg;
                        ol_next   = 1'b0;
                        ou_next   = 1'b0;
                        mk_next   = e_len;
                        open_next = OPEN_MARK;
                    end
                    default: begin
                        mk_next   = e_len;
                        open_next = OPEN_MARK;
                    end
                endcase
            end else begin
                case (open_reg)
                    OPEN_MARK: begin
                        sp_next   = e_len;
                        open_next = OPEN_SPACE;
                    end
                    OPEN_SPACE: sp_next = sp_reg + e_len;
                    default:    open_next = OPEN_NONE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= OPEN_NONE;
            ov_reg   <= 1'b0;
        end else begin
            open_reg <= open_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        mk_reg <= mk_next;
        sp_reg <= sp_next;
        op_reg <= op_next;
        os_reg <= os_next;
        ol_reg <= ol_next;
        ou_reg <= ou_next;
    end

    assign out_valid = ov_reg;
    assign out_pulse = op_reg;
    assign out_space = os_reg;
    assign out_last  = ol_reg;
    assign out_unsup = ou_reg;

endmodule

// ----- src/ir_scancode_pulse_encoder.sv -----
// channel   direction  tdata                                     tuser         tlast
// s_        in         [4:0] cmd, [36:5] scancode, pad to 40     -             -
// m_        out        [15:0] pulse_us, [31:16] space_us          unsupported   last
//
// one word in, then a run of pairs; the frame sequencer steps one mark or
// space edge per cycle unless a stalled output holds it (sanyo gives the
// longest frame).
// synchronous active-low reset clears the sequencer and the output valid.
// a stalled output holds the sequencer when a pair is due; the next word
// is taken once the final pair sits in the output register.
module ir_scancode_pulse_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] cmd, [36:5] scancode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] pulse_us, [31:16] space_us
    output logic        m_tlast,
    output logic        m_tuser    // [0] unsupported
);

    irsc_pkg::ctrl_cmd_t cmd;
    irsc_pkg::dp_stat_t  stat;
    logic [15:0]         pulse;
    logic [15:0]         space;

    irsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    irsc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_cmd      (s_tdata[4:0]),
        .in_scancode (s_tdata[36:5]),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pulse   (pulse),
        .out_space   (space),
        .out_last    (m_tlast),
        .out_unsup   (m_tuser)
    );

    assign m_tdata = {space, pulse};

    // flagged word is a single zero pair
    a_unsup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 32'd0))
        else $error("unsupported word not a zero final pair");

    // final pair has no trailing space
    a_last_space: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[31:16] == 16'd0))
        else $error("final pair carries a space");

    // busy after taking a word
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

endmodule

// ----- sim/tb.sv -----
module tb;

    typedef struct {
        logic [15:0] pulse_us;
        logic [15:0] space_us;
        logic        last;
        logic        unsupported;
    } pair_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    pair_t       pair_q[$];
    int          mismatches;
    bit          no_gaps;
    bit          hold_rx;
    int          hold_cycles;

    ir_scancode_pulse_encoder u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // edge list builder, merges like edges
    logic [31:0] edges[$];

    function automatic void add_mark(input logic [31:0] len);
        if (edges.size() % 2 == 1) edges[edges.size() - 1] += len;
        else edges.push_back(len);
    endfunction

    function automatic void add_space(input logic [31:0] len);
        if (edges.size() == 0) return;
        if (edges.size() % 2 == 0) edges[edges.size() - 1] += len;
        else edges.push_back(len);
    endfunction

    function automatic void dist_bits(input logic [31:0] v, input int n,
                                      input logic [31:0] mk_len, input logic [31:0] s0,
                                      input logic [31:0] s1);
        for (int i = 0; i < n; i++) begin
            add_mark(mk_len);
            add_space(v[i] ? s1 : s0);
        end
    endfunction

    function automatic void width_bits(input logic [31:0] v, input int n,
                                       input logic [31:0] m0, input logic [31:0] m1,
                                       input logic [31:0] sp);
        for (int i = 0; i < n; i++) begin
            add_mark(v[i] ? m1 : m0);
            add_space(sp);
        end
    endfunction

    function automatic void manch_bits(input logic [31:0] v, input int n,
                                       input logic [31:0] len, input bit one_mark);
        for (int i = n - 1; i >= 0; i--) begin
            if (v[i] == one_mark) begin
                add_mark(len);
                add_space(len);
            end else begin
                add_space(len);
                add_mark(len);
            end
        end
    endfunction

    // build the expected pair run of one frame
    function automatic void predict_frame(input logic [4:0] cmd, input logic [31:0] s);
        pair_t p;
        int    npairs;
        logic [31:0] w;
        edges.delete();
        case (cmd)
            irsc_pkg::CMD_RC5, irsc_pkg::CMD_RC5X, irsc_pkg::CMD_RC5SZ: begin
                add_mark(889);
                if (cmd == irsc_pkg::CMD_RC5) begin
                    manch_bits(~s[6], 1, 889, 1'b0);
                    manch_bits(0, 1, 889, 1'b0);
                    manch_bits(s >> 8, 5, 889, 1'b0);
                    manch_bits(s, 6, 889, 1'b0);
                end else if (cmd == irsc_pkg::CMD_RC5SZ) begin
                    manch_bits(s[13], 1, 889, 1'b0);
                    manch_bits(0, 1, 889, 1'b0);
                    manch_bits(s >> 6, 6, 889, 1'b0);
                    manch_bits(s, 6, 889, 1'b0);
                end else begin
                    manch_bits(~s[14], 1, 889, 1'b0);
                    manch_bits(0, 1, 889, 1'b0);
                    manch_bits(s >> 16, 5, 889, 1'b0);
                    add_space(3556);
                    manch_bits(s >> 8, 6, 889, 1'b0);
                    manch_bits(s, 6, 889, 1'b0);
                end
            end
            irsc_pkg::CMD_SONY12, irsc_pkg::CMD_SONY15, irsc_pkg::CMD_SONY20: begin
                add_mark(2400);
                add_space(600);
                width_bits(s, 7, 600, 1200, 600);
                if (cmd == irsc_pkg::CMD_SONY15) width_bits(s >> 16, 8, 600, 1200, 600);
                else width_bits(s >> 16, 5, 600, 1200, 600);
                if (cmd == irsc_pkg::CMD_SONY20) width_bits(s >> 8, 8, 600, 1200, 600);
            end
            irsc_pkg::CMD_JVC: begin
                w = {16'd0, s[7:0], s[15:8]};
                add_mark(8400);
                add_space(4200);
                dist_bits(w, 16, 525, 525, 1575);
                add_mark(525);
            end
            irsc_pkg::CMD_NEC, irsc_pkg::CMD_NECX, irsc_pkg::CMD_NEC32: begin
                add_mark(9000);
                add_space(4500);
                if (cmd == irsc_pkg::CMD_NEC) begin
                    dist_bits(s >> 8, 8, 563, 563, 1688);
                    dist_bits(~(s >> 8), 8, 563, 563, 1688);
                    dist_bits(s, 8, 563, 563, 1688);
                    dist_bits(~s, 8, 563, 563, 1688);
                end else if (cmd == irsc_pkg::CMD_NECX) begin
                    dist_bits(s >> 16, 8, 563, 563, 1688);
                    dist_bits(s >> 8, 8, 563, 563, 1688);
                    dist_bits(s, 8, 563, 563, 1688);
                    dist_bits(~s, 8, 563, 563, 1688);
                end else begin
                    dist_bits(s >> 16, 8, 563, 563, 1688);
                    dist_bits(s >> 24, 8, 563, 563, 1688);
                    dist_bits(s, 8, 563, 563, 1688);
                    dist_bits(s >> 8, 8, 563, 563, 1688);
                end
                add_mark(563);
            end
            irsc_pkg::CMD_SANYO: begin
                add_mark(9000);
                add_space(4500);
                dist_bits(s >> 8, 13, 563, 563, 1688);
                dist_bits(~(s >> 8), 13, 563, 563, 1688);
                dist_bits(s, 8, 563, 563, 1688);
                dist_bits(~s, 8, 563, 563, 1688);
                add_mark(563);
            end
            irsc_pkg::CMD_RC6_0, irsc_pkg::CMD_RC6_20, irsc_pkg::CMD_RC6_24,
            irsc_pkg::CMD_RC6_32, irsc_pkg::CMD_RC6_MCE: begin
                add_mark(2667);
                add_space(889);
                manch_bits((cmd == irsc_pkg::CMD_RC6_0) ? 8 : 14, 4, 444, 1'b1);
                manch_bits(0, 1, 889, 1'b1);
                case (cmd)
                    irsc_pkg::CMD_RC6_0:  manch_bits(s, 16, 444, 1'b1);
                    irsc_pkg::CMD_RC6_20: manch_bits(s, 20, 444, 1'b1);
                    irsc_pkg::CMD_RC6_24: manch_bits(s, 24, 444, 1'b1);
                    default:              manch_bits(s, 32, 444, 1'b1);
                endcase
            end
            irsc_pkg::CMD_SHARP: begin
                dist_bits(s >> 8, 5, 320, 680, 1680);
                dist_bits(s, 8, 320, 680, 1680);
                dist_bits(1, 2, 320, 680, 1680);
                add_mark(320);
                add_space(40000);
                dist_bits(s >> 8, 5, 320, 680, 1680);
                dist_bits(~s, 8, 320, 680, 1680);
                dist_bits(~32'd1, 2, 320, 680, 1680);
                add_mark(320);
            end
            irsc_pkg::CMD_DVD: begin
                w = {8'd0, ~s[11:0], s[11:0]};
                add_mark(4000);
                add_space(3900);
                for (int i = 23; i >= 0; i--) begin
                    add_mark(550);
                    add_space(w[i] ? 1900 : 900);
                end
                add_mark(550);
            end
            default: begin
                p = '{16'd0, 16'd0, 1'b1, 1'b1};
                pair_q.push_back(p);
                return;
            end
        endcase
        if (edges.size() % 2 == 0) void'(edges.pop_back());
        npairs = (edges.size() + 1) / 2;
        if (npairs > 44) npairs = 44;
        for (int k = 0; k < npairs; k++) begin
            p.pulse_us    = edges[2 * k][15:0];
            p.space_us    = (2 * k + 1 < edges.size() && k + 1 < npairs)
                            ? edges[2 * k + 1][15:0] : 16'd0;
            p.last        = (k + 1 == npairs);
            p.unsupported = 1'b0;
            pair_q.push_back(p);
        end
    endfunction

    // send one word, with an optional random gap before it
    task automatic send_word(input logic [4:0] cmd, input logic [31:0] s);
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, s, cmd};
        predict_frame(cmd, s);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_code();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        for (int c = 0; c <= 17; c++) send_word(c[4:0], (c % 2) ? 32'hffff_ffff : 32'd0);
        send_word(irsc_pkg::CMD_RC5, 32'h0000_0040);
        send_word(irsc_pkg::CMD_RC5X, 32'h0000_4000);
        send_word(irsc_pkg::CMD_RC5SZ, 32'h0000_2000);
        send_word(5'd18, 32'h1234_5678);
        send_word(5'd31, 32'hffff_ffff);
        send_word(irsc_pkg::CMD_DVD, 32'h0000_0a5c);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        hold_rx = 1'b1;
        for (int i = 0; i < 6; i++) send_word(irsc_pkg::CMD_SANYO, $urandom);
    endtask

    task automatic test_random(input int n);
        logic [4:0] cmd;
        for (int i = 0; i < n; i++) begin
            // mostly supported protocols, some unsupported codes
            cmd = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(18, 31))
                                              : 5'($urandom_range(0, 17));
            send_word(cmd, rand_code());
        end
    endtask

    task automatic test_no_gaps(input int n);
        no_gaps = 1'b1;
        test_random(n);
    endtask

    // receiver ready, random stall bursts and one long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_rx = 1'b0;
                m_tready <= 1'b1;
            end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // check each pair against the oldest expectation
    initial begin
        pair_t exp_p;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pair_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: pulse %0d space %0d last %0d unsup %0d",
                                 m_tdata[15:0], m_tdata[31:16], m_tlast, m_tuser);
                end else begin
                    exp_p = pair_q.pop_front();
                    if (m_tdata[15:0] !== exp_p.pulse_us || m_tdata[31:16] !== exp_p.space_us
                        || m_tlast !== exp_p.last || m_tuser !== exp_p.unsupported) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     exp_p.pulse_us, exp_p.space_us, exp_p.last,
                                     exp_p.unsupported, m_tdata[15:0], m_tdata[31:16],
                                     m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("ir_scancode_pulse_encoder verification failed");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        mismatches = 0;
        no_gaps  = 1'b0;
        hold_rx  = 1'b0;
        hold_cycles = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_backpressure();
        test_random(230);
        test_no_gaps(60);
        s_tvalid <= 1'b0;
        while (pair_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && pair_q.size() == 0) begin
            $display("ir_scancode_pulse_encoder verification clean");
        end else begin
            $display("ir_scancode_pulse_encoder verification failed");
        end
        $finish;
    end

endmodule
